### hdl/f32_to_fp8_converter_top_assert.svh
// assertion macros for the fp8 converter
`ifndef F32_TO_FP8_CONVERTER_TOP_ASSERT_SVH
`define F32_TO_FP8_CONVERTER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define FP8_ASSERT_IMPL(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define FP8_ASSERT_RST(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FP8_ASSERT_IMPL(label, clk, rst, prop, msg)
`define FP8_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

### hdl/f2f8_pkg.sv
`timescale 1ns / 1ps
package f2f8_pkg;
   localparam logic [2:0] RM_RNE = 3'd0;
   localparam logic [2:0] RM_RTZ = 3'd1;
   localparam logic [2:0] RM_RDN = 3'd2;
   localparam logic [2:0] RM_RUP = 3'd3;
   localparam logic [2:0] RM_RMM = 3'd4;
   localparam logic [2:0] RM_ODD = 3'd5;
   localparam logic [1:0] CSR_FORMAT = 2'd0;
   localparam logic [1:0] CSR_RMODE = 2'd1;
   localparam logic [1:0] CSR_TINY = 2'd2;

   // stage 1 to stage 2
   typedef struct packed {
      logic       special;
      logic [7:0] special_res;
      logic       special_inv;
      logic       sign;
      logic       e4;
      logic       near_even;
      logic       odd;
      logic [3:0] inc;
      logic [9:0] exp;
      logic [8:0] sig;
      logic       tiny_mode_after;
   } dec_type;

   // stage 2 to stage 3
   typedef struct packed {
      logic       special;
      logic [7:0] special_res;
      logic       special_inv;
      logic       sign;
      logic       e4;
      logic       near_even;
      logic       odd;
      logic [3:0] inc;
      logic [9:0] exp;
      logic [8:0] sig;
      logic       unf;
   } aln_type;

   typedef struct packed {
      logic [7:0] fp8;
      logic       inv;
      logic       ovf;
      logic       unf;
      logic       inx;
   } res_type;
endpackage

### hdl/f2f8_decode.sv
`timescale 1ns / 1ps
module f2f8_decode import f2f8_pkg::*; (
   input  logic [31:0] single_bits,
   input  logic        fmt,
   input  logic [2:0]  rmode,
   input  logic        tiny_after,
   output dec_type     dec
);
   logic        e4, sign;
   logic [7:0]  ex;
   logic [22:0] frac;
   logic [8:0]  sig;
   always_comb begin
      e4   = ~fmt;
      sign = single_bits[31];
      ex   = single_bits[30:23];
      frac = single_bits[22:0];
      if (e4) sig = {2'b0, frac[22:16]} | {8'b0, |frac[15:0]};
      else    sig = {3'b0, frac[22:17]} | {8'b0, |frac[16:0]};
      dec = '0;
      dec.sign = sign;
      dec.e4 = e4;
      dec.near_even = (rmode == RM_RNE);
      dec.odd = (rmode == RM_ODD);
      dec.tiny_mode_after = tiny_after;
      if (rmode == RM_RNE || rmode == RM_RMM) dec.inc = 4'h8;
      else if (rmode == (sign ? RM_RDN : RM_RUP)) dec.inc = 4'hF;
      else dec.inc = 4'h0;
      if (ex == 8'hFF) begin
         dec.special = 1'b1;
         if (frac != '0) begin
            dec.special_res = e4 ? 8'h7F : 8'h7E;
            dec.special_inv = ~frac[22];
         end else begin
            dec.special_res = {sign, e4 ? 7'h7F : 7'h7C};
         end
      end else if (ex == 8'h00 && sig == '0) begin
         dec.special = 1'b1;
         dec.special_res = {sign, 7'h00};
      end
      dec.sig = sig | (e4 ? 9'h080 : 9'h040);
      dec.exp = {2'b0, ex} - (e4 ? 10'd121 : 10'd113);
   end
endmodule

### hdl/f2f8_align.sv
`timescale 1ns / 1ps
module f2f8_align import f2f8_pkg::*; (
   input  dec_type d,
   output aln_type a
);
   logic       tiny;
   logic [9:0] shamt;
   logic [8:0] sh;
   logic [9:0] sum;
   logic [8:0] carry;
   always_comb begin
      a = '0;
      a.special = d.special;
      a.special_res = d.special_res;
      a.special_inv = d.special_inv;
      a.sign = d.sign;
      a.e4 = d.e4;
      a.near_even = d.near_even;
      a.odd = d.odd;
      a.inc = d.inc;
      a.exp = d.exp;
      a.sig = d.sig;
      carry = d.e4 ? 9'h100 : 9'h080;
      sum = {1'b0, d.sig} + {6'b0, d.inc};
      shamt = -d.exp;
      tiny = ~d.tiny_mode_after || ($signed(d.exp) < -10'sd1) || (sum < {1'b0, carry});
      sh = '0;
      if (d.exp[9]) begin
         if (shamt >= 10'd16) sh = {8'b0, |d.sig};
         else sh = (d.sig >> shamt[3:0]) |
                   {8'b0, |(d.sig & ~(9'h1FF << shamt[3:0]))};
         a.sig = sh;
         a.exp = '0;
         a.unf = tiny && (sh[3:0] != 4'h0);
      end
   end
endmodule

### hdl/f2f8_round.sv
`timescale 1ns / 1ps
module f2f8_round import f2f8_pkg::*; (
   input  aln_type a,
   output res_type r
);
   logic [3:0] rbits;
   logic [9:0] s;
   logic [5:0] sig;
   logic [9:0] emax;
   logic [5:0] sovf;
   logic [7:0] ovc;
   logic [9:0] ex;
   always_comb begin
      r = '0;
      rbits = a.sig[3:0];
      s = {1'b0, a.sig} + {6'b0, a.inc};
      sig = s[9:4];
      if (a.near_even && rbits == 4'h8) sig[0] = 1'b0;
      if (a.odd && rbits != 4'h0) sig[0] = 1'b1;
      emax = a.e4 ? 10'd14 : 10'd29;
      sovf = a.e4 ? 6'd15 : 6'd8;
      ovc = {a.sign, a.e4 ? 7'h7F : 7'h7C};
      ex = (sig == '0) ? 10'd0 : a.exp;
      if (a.special) begin
         r.fp8 = a.special_res;
         r.inv = a.special_inv;
      end else if ($signed(a.exp) > $signed(emax) || (a.exp == emax && sig >= sovf)) begin
         r.ovf = 1'b1;
         r.inx = 1'b1;
         r.fp8 = ovc - ((a.inc == 4'h0) ? 8'd1 : 8'd0);
      end else begin
         r.unf = a.unf;
         r.inx = (rbits != 4'h0);
         r.fp8 = {a.sign, 7'h00} + (a.e4 ? {ex[4:0], 3'b0} : {1'b0, ex[4:0], 2'b0})
                 + {2'b0, sig};
      end
   end
endmodule

### hdl/f32_to_fp8_converter_top.sv
`timescale 1ns / 1ps
// binary32 to fp8 (e4m3 or e5m2) converter
// req channel: req_valid/req_stall carry one binary32 beat in req_single_bits
// rsp channel: rsp_valid/rsp_stall carry fp8 result plus four exception flags
// a beat moves when valid is high and stall is low
// csr port: csr_write_enable, csr_index, csr_write_data; write only while idle
//   index 0 format (0 e4m3, 1 e5m2), 1 rounding mode, 2 tininess after rounding
// pipeline: three register stages from req beat to rsp valid
//   (decode, subnormal align, round and pack)
// throughput: one beat per cycle unless stalled, set by the pipeline stage advance
// reset: pipeline empties, format e4m3, nearest-even, tininess after rounding
// stall: rsp_stall freezes the whole pipeline when the last stage holds a result;
//   req_stall is raised in that same case; no beat is lost
module f32_to_fp8_converter_top import f2f8_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_single_bits,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_fp8_bits,
   output logic        rsp_invalid_flag,
   output logic        rsp_overflow_flag,
   output logic        rsp_underflow_flag,
   output logic        rsp_inexact_flag,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [2:0]  csr_write_data
);
`include "f32_to_fp8_converter_top_assert.svh"
   logic       fmt_ff, tiny_ff;
   logic [2:0] rmode_ff;
   logic       v1_ff, v2_ff, v3_ff;
   dec_type    dec_in, dec_ff;
   aln_type    aln_in, aln_ff;
   res_type    res_in, res_ff;
   logic       adv;

   assign adv = ~(v3_ff & rsp_stall);
   assign req_stall = ~adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff <= 1'b0;
         rmode_ff <= RM_RNE;
         tiny_ff <= 1'b1;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_FORMAT: fmt_ff <= csr_write_data[0];
            CSR_RMODE:  rmode_ff <= csr_write_data;
            CSR_TINY:   tiny_ff <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   f2f8_decode u_dec (
      .single_bits(req_single_bits), .fmt(fmt_ff), .rmode(rmode_ff),
      .tiny_after(tiny_ff), .dec(dec_in)
   );
   f2f8_align u_aln (.d(dec_ff), .a(aln_in));
   f2f8_round u_rnd (.a(aln_ff), .r(res_in));

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dec_ff <= dec_in;
         aln_ff <= aln_in;
         res_ff <= res_in;
      end
   end

   assign rsp_valid = v3_ff;
   assign rsp_fp8_bits = res_ff.fp8;
   assign rsp_invalid_flag = res_ff.inv;
   assign rsp_overflow_flag = res_ff.ovf;
   assign rsp_underflow_flag = res_ff.unf;
   assign rsp_inexact_flag = res_ff.inx;

   `FP8_ASSERT_IMPL(a_hold, clock, reset, (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(res_ff)), "result changed under stall")
   `FP8_ASSERT_IMPL(a_move, clock, reset, (!req_stall && v2_ff) |=> rsp_valid, "stage 2 beat lost")
   `FP8_ASSERT_IMPL(a_ovf, clock, reset, rsp_valid && rsp_overflow_flag |-> rsp_inexact_flag && !rsp_underflow_flag, "overflow without inexact")
   `FP8_ASSERT_RST(a_rst, clock, reset |=> !rsp_valid, "valid after reset")
endmodule
